>>> src/ascr_pkg.sv
// Package for the address space controller register file.
// Holds the register offsets, write masks, identification bytes and status codes.
// No dependencies.
package ascr_pkg;

  localparam int MAX_REGIONS_DEF = 16;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_BAD    = 2'd1;
  localparam logic [1:0] ST_LOCKED = 2'd2;

  localparam logic [11:0] OFF_CONFIG    = 12'h000;
  localparam logic [11:0] OFF_ACTION    = 12'h004;
  localparam logic [11:0] OFF_LOCK_RNG  = 12'h008;
  localparam logic [11:0] OFF_LOCK_SEL  = 12'h00C;
  localparam logic [11:0] OFF_INT_STAT  = 12'h010;
  localparam logic [11:0] OFF_INT_CLR   = 12'h014;
  localparam logic [11:0] OFF_FAIL_ADDR = 12'h020;
  localparam logic [11:0] OFF_FAIL_HIGH = 12'h024;
  localparam logic [11:0] OFF_FAIL_CTRL = 12'h028;
  localparam logic [11:0] OFF_FAIL_ID   = 12'h02C;
  localparam logic [11:0] OFF_SPEC      = 12'h030;
  localparam logic [11:0] OFF_SEC_INV   = 12'h034;
  localparam logic [11:0] OFF_PERIPH4   = 12'hFD0;
  localparam logic [11:0] OFF_PERIPH0   = 12'hFE0;
  localparam logic [11:0] OFF_PERIPH1   = 12'hFE4;
  localparam logic [11:0] OFF_PERIPH2   = 12'hFE8;
  localparam logic [11:0] OFF_PERIPH3   = 12'hFEC;
  localparam logic [11:0] OFF_CELL0     = 12'hFF0;
  localparam logic [11:0] OFF_CELL1     = 12'hFF4;
  localparam logic [11:0] OFF_CELL2     = 12'hFF8;
  localparam logic [11:0] OFF_CELL3     = 12'hFFC;
  localparam logic [11:0] OFF_REGION_LO = 12'h100;
  localparam logic [11:0] OFF_REGION_HI = 12'h1FC;

  localparam logic [3:0] SUB_LOW   = 4'h0;
  localparam logic [3:0] SUB_HIGH  = 4'h4;
  localparam logic [3:0] SUB_ATTRS = 4'h8;

  localparam logic [31:0] CONFIG_BASE     = 32'h0000_1F00;
  localparam logic [31:0] LOW_MASK        = 32'hFFFF_0000;
  localparam logic [31:0] ATTR0_MASK      = 32'hF000_0000;
  localparam logic [31:0] ATTR0_FORCE     = 32'h0000_003F;
  localparam logic [31:0] ATTR_MASK       = 32'hF000_FF7F;
  localparam logic [31:0] LOCK_RNG_MASK   = 32'h8000_000F;
  localparam logic [31:0] ALL_ONES        = 32'hFFFF_FFFF;

  localparam logic [7:0] PERIPH_BYTE0 = 8'h80;
  localparam logic [7:0] PERIPH_BYTE1 = 8'hB3;
  localparam logic [7:0] PERIPH_BYTE2 = 8'h1B;
  localparam logic [7:0] PERIPH_BYTE3 = 8'h00;
  localparam logic [7:0] PERIPH_BYTE4 = 8'h04;
  localparam logic [7:0] CELL_BYTE0   = 8'h0D;
  localparam logic [7:0] CELL_BYTE1   = 8'hF0;
  localparam logic [7:0] CELL_BYTE2   = 8'h05;
  localparam logic [7:0] CELL_BYTE3   = 8'hB1;

  localparam logic [4:0] REGIONS_RESET = 5'd16;

endpackage

>>> src/address_space_controller_regs_unit.sv
// Address space controller register file: one bus access per item.
// An accepted item is registered, then decoded against the register set and
// its result registered once the output is free. One item can be taken in
// every cycle unless a stalled output holds the result and raises in_stall.
// Reset is synchronous and active low: control, region and valid registers
// clear to zero, the region count returns to 16; data registers are not reset.
module address_space_controller_regs_unit
  import ascr_pkg::*;
#(
  parameter int MAX_REGIONS = MAX_REGIONS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write_en,
  input  logic [4:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_mode,
  input  logic [11:0] in_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic [1:0]  out_status
);

  localparam int RIDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam logic [4:0] MAX_CNT = 5'(MAX_REGIONS);

  logic [4:0]  regions_r;
  logic [31:0] region_low_r   [MAX_REGIONS];
  logic [31:0] region_high_r  [MAX_REGIONS];
  logic [31:0] region_attrs_r [MAX_REGIONS];
  logic [1:0]  action_r, action_nxt;
  logic [31:0] lock_range_r, lock_range_nxt;
  logic [2:0]  lock_select_r, lock_select_nxt;
  logic [1:0]  spec_r, spec_nxt;
  logic        sec_inv_r, sec_inv_nxt;

  logic        s1_valid_r;
  logic        s1_mode_r;
  logic [11:0] s1_offset_r;
  logic [31:0] s1_data_r;

  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic [1:0]  out_status_r;

  logic        advance;
  logic        accept;
  logic [4:0]  count;
  logic [4:0]  locked;
  logic [4:0]  first_locked;
  logic        region_hit;
  logic [3:0]  reg_sel;
  logic [3:0]  sub_sel;
  logic        r_ok;
  logic [RIDX_W-1:0] ridx;
  logic        wr_low, wr_high, wr_attrs;
  logic [31:0] attr_val;
  logic [31:0] rd_data;
  logic [1:0]  rd_status;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign accept    = in_valid && !in_stall;
  assign out_valid     = out_valid_r;
  assign out_read_data = out_read_data_r;
  assign out_status    = out_status_r;

  always_comb begin
    if (regions_r == 5'd0) begin
      count = 5'd1;
    end else if (regions_r > MAX_CNT) begin
      count = MAX_CNT;
    end else begin
      count = regions_r;
    end
    locked = {1'b0, lock_range_r[3:0]} + 5'd1;
    if (lock_range_r[31]) begin
      first_locked = (locked < count) ? count - locked : 5'd0;
    end else begin
      first_locked = count;
    end
  end

  always_comb begin
    region_hit = (s1_offset_r >= OFF_REGION_LO) && (s1_offset_r <= OFF_REGION_HI);
    reg_sel    = s1_offset_r[7:4];
    sub_sel    = s1_offset_r[3:0];
    r_ok       = {1'b0, reg_sel} < count;
    ridx       = reg_sel[RIDX_W-1:0];
    attr_val   = (reg_sel == 4'd0) ? ((s1_data_r & ATTR0_MASK) | ATTR0_FORCE)
                                   : (s1_data_r & ATTR_MASK);

    rd_data         = '0;
    rd_status       = ST_DONE;
    wr_low          = 1'b0;
    wr_high         = 1'b0;
    wr_attrs        = 1'b0;
    action_nxt      = action_r;
    lock_range_nxt  = lock_range_r;
    lock_select_nxt = lock_select_r;
    spec_nxt        = spec_r;
    sec_inv_nxt     = sec_inv_r;

    if (!s1_mode_r) begin
      if (region_hit) begin
        if (!r_ok) begin
          rd_data   = ALL_ONES;
          rd_status = ST_BAD;
        end else begin
          case (sub_sel)
            SUB_LOW:   rd_data = region_low_r[ridx];
            SUB_HIGH:  rd_data = region_high_r[ridx];
            SUB_ATTRS: rd_data = region_attrs_r[ridx];
            default: begin
              rd_data   = ALL_ONES;
              rd_status = ST_BAD;
            end
          endcase
        end
      end else begin
        case (s1_offset_r)
          OFF_CONFIG:   rd_data = CONFIG_BASE | {27'd0, count - 5'd1};
          OFF_ACTION:   rd_data = {30'd0, action_r};
          OFF_LOCK_RNG: rd_data = lock_range_r;
          OFF_LOCK_SEL: rd_data = {29'd0, lock_select_r};
          OFF_INT_STAT, OFF_FAIL_ADDR, OFF_FAIL_HIGH, OFF_FAIL_CTRL, OFF_FAIL_ID:
            rd_data = '0;
          OFF_SPEC:     rd_data = {30'd0, spec_r};
          OFF_SEC_INV:  rd_data = {31'd0, sec_inv_r};
          OFF_PERIPH4:  rd_data = {24'd0, PERIPH_BYTE4};
          OFF_PERIPH0:  rd_data = {24'd0, PERIPH_BYTE0};
          OFF_PERIPH1:  rd_data = {24'd0, PERIPH_BYTE1};
          OFF_PERIPH2:  rd_data = {24'd0, PERIPH_BYTE2};
          OFF_PERIPH3:  rd_data = {24'd0, PERIPH_BYTE3};
          OFF_CELL0:    rd_data = {24'd0, CELL_BYTE0};
          OFF_CELL1:    rd_data = {24'd0, CELL_BYTE1};
          OFF_CELL2:    rd_data = {24'd0, CELL_BYTE2};
          OFF_CELL3:    rd_data = {24'd0, CELL_BYTE3};
          default:      rd_status = ST_BAD;
        endcase
      end
    end else begin
      if (region_hit) begin
        if (!r_ok) begin
          rd_status = ST_BAD;
        end else if ({1'b0, reg_sel} >= first_locked) begin
          rd_status = ST_LOCKED;
        end else begin
          case (sub_sel)
            SUB_LOW:   wr_low   = 1'b1;
            SUB_HIGH:  wr_high  = 1'b1;
            SUB_ATTRS: wr_attrs = 1'b1;
            default:   rd_status = ST_BAD;
          endcase
        end
      end else begin
        case (s1_offset_r)
          OFF_ACTION:   action_nxt = s1_data_r[1:0];
          OFF_LOCK_RNG: begin
            if (lock_select_r[0]) begin
              rd_status = ST_LOCKED;
            end else begin
              lock_range_nxt = s1_data_r & LOCK_RNG_MASK;
            end
          end
          OFF_LOCK_SEL: lock_select_nxt = s1_data_r[2:0];
          OFF_INT_CLR:  rd_status = ST_DONE;
          OFF_SPEC: begin
            if (lock_select_r[2]) begin
              rd_status = ST_LOCKED;
            end else begin
              spec_nxt = s1_data_r[1:0];
            end
          end
          OFF_SEC_INV: begin
            if (lock_select_r[1]) begin
              rd_status = ST_LOCKED;
            end else begin
              sec_inv_nxt = s1_data_r[0];
            end
          end
          default: rd_status = ST_BAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regions_r     <= REGIONS_RESET;
      action_r      <= '0;
      lock_range_r  <= '0;
      lock_select_r <= '0;
      spec_r        <= '0;
      sec_inv_r     <= 1'b0;
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      for (int i = 0; i < MAX_REGIONS; i++) begin
        region_low_r[i]   <= '0;
        region_high_r[i]  <= '0;
        region_attrs_r[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        regions_r <= cfg_write_data;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r   <= 1'b1;
        action_r      <= action_nxt;
        lock_range_r  <= lock_range_nxt;
        lock_select_r <= lock_select_nxt;
        spec_r        <= spec_nxt;
        sec_inv_r     <= sec_inv_nxt;
        if (wr_low) begin
          region_low_r[ridx] <= s1_data_r & LOW_MASK;
        end
        if (wr_high) begin
          region_high_r[ridx] <= s1_data_r;
        end
        if (wr_attrs) begin
          region_attrs_r[ridx] <= attr_val;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode_r   <= in_mode;
      s1_offset_r <= in_offset;
      s1_data_r   <= in_write_data;
    end
    if (advance) begin
      out_read_data_r <= rd_data;
      out_status_r    <= rd_status;
    end
  end

endmodule

>>> verif/tb_address_space_controller_regs_unit.sv
// Testbench for the address space controller register file unit.
// It drives bus accesses and region count settings, predicts each result and checks it.
// It depends on ascr_pkg and address_space_controller_regs_unit.
module tb_address_space_controller_regs_unit;
  import ascr_pkg::*;

  localparam bit ACC_READ  = 1'b0;
  localparam bit ACC_WRITE = 1'b1;

  typedef struct packed {
    logic [31:0] read_data;
    logic [1:0]  status;
  } access_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_write_en;
  logic [4:0]  cfg_write_data;
  logic        in_valid;
  logic        in_stall;
  logic        in_mode;
  logic [11:0] in_offset;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_read_data;
  logic [1:0]  out_status;

  access_result_t pending_results[$];
  access_result_t oldest_result;
  int unsigned    error_count = 0;
  int unsigned    send_idle_pct = 13;
  int unsigned    stall_pct = 62;

  logic [4:0]  regions_setting;
  logic [31:0] shadow_region_low [MAX_REGIONS_DEF];
  logic [31:0] shadow_region_high [MAX_REGIONS_DEF];
  logic [31:0] shadow_region_attrs [MAX_REGIONS_DEF];
  logic [1:0]  shadow_action;
  logic [31:0] shadow_lock_range;
  logic [2:0]  shadow_lock_select;
  logic [1:0]  shadow_spec;
  logic        shadow_sec_inv;

  logic [11:0] named_offsets [21] = '{
    OFF_CONFIG, OFF_ACTION, OFF_LOCK_RNG, OFF_LOCK_SEL, OFF_INT_STAT, OFF_INT_CLR,
    OFF_FAIL_ADDR, OFF_FAIL_HIGH, OFF_FAIL_CTRL, OFF_FAIL_ID, OFF_SPEC, OFF_SEC_INV,
    OFF_PERIPH4, OFF_PERIPH0, OFF_PERIPH1, OFF_PERIPH2, OFF_PERIPH3,
    OFF_CELL0, OFF_CELL1, OFF_CELL2, OFF_CELL3
  };

  address_space_controller_regs_unit i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_write_en  (cfg_write_en),
    .cfg_write_data(cfg_write_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_mode       (in_mode),
    .in_offset     (in_offset),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_status    (out_status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned active_regions();
    if (regions_setting == 5'd0) return 1;
    if (regions_setting > MAX_REGIONS_DEF) return MAX_REGIONS_DEF;
    return {27'd0, regions_setting};
  endfunction

  function automatic int unsigned first_locked_region();
    int unsigned n;
    int unsigned locked;
    n = active_regions();
    if (!shadow_lock_range[31]) return n;
    locked = {28'd0, shadow_lock_range[3:0]} + 1;
    return (locked < n) ? n - locked : 0;
  endfunction

  function automatic logic [11:0] region_offset(logic [3:0] region, logic [3:0] sub);
    return OFF_REGION_LO | {region, sub};
  endfunction

  function automatic access_result_t decode_read(logic [11:0] off);
    access_result_t res;
    int unsigned r;
    res.read_data = '0;
    res.status = ST_DONE;
    if (off >= OFF_REGION_LO && off <= OFF_REGION_HI) begin
      r = {28'd0, off[7:4]};
      if (r >= active_regions()) begin
        res.read_data = ALL_ONES;
        res.status = ST_BAD;
      end else begin
        case (off[3:0])
          SUB_LOW:   res.read_data = shadow_region_low[r];
          SUB_HIGH:  res.read_data = shadow_region_high[r];
          SUB_ATTRS: res.read_data = shadow_region_attrs[r];
          default: begin
            res.read_data = ALL_ONES;
            res.status = ST_BAD;
          end
        endcase
      end
      return res;
    end
    case (off)
      OFF_CONFIG:   res.read_data = CONFIG_BASE | (active_regions() - 1);
      OFF_ACTION:   res.read_data = {30'b0, shadow_action};
      OFF_LOCK_RNG: res.read_data = shadow_lock_range;
      OFF_LOCK_SEL: res.read_data = {29'b0, shadow_lock_select};
      OFF_INT_STAT, OFF_FAIL_ADDR, OFF_FAIL_HIGH, OFF_FAIL_CTRL, OFF_FAIL_ID:
        res.read_data = '0;
      OFF_SPEC:     res.read_data = {30'b0, shadow_spec};
      OFF_SEC_INV:  res.read_data = {31'b0, shadow_sec_inv};
      OFF_PERIPH4:  res.read_data = {24'b0, PERIPH_BYTE4};
      OFF_PERIPH0:  res.read_data = {24'b0, PERIPH_BYTE0};
      OFF_PERIPH1:  res.read_data = {24'b0, PERIPH_BYTE1};
      OFF_PERIPH2:  res.read_data = {24'b0, PERIPH_BYTE2};
      OFF_PERIPH3:  res.read_data = {24'b0, PERIPH_BYTE3};
      OFF_CELL0:    res.read_data = {24'b0, CELL_BYTE0};
      OFF_CELL1:    res.read_data = {24'b0, CELL_BYTE1};
      OFF_CELL2:    res.read_data = {24'b0, CELL_BYTE2};
      OFF_CELL3:    res.read_data = {24'b0, CELL_BYTE3};
      default:      res.status = ST_BAD;
    endcase
    return res;
  endfunction

  function automatic logic [1:0] apply_write(logic [11:0] off, logic [31:0] v);
    int unsigned r;
    if (off >= OFF_REGION_LO && off <= OFF_REGION_HI) begin
      r = {28'd0, off[7:4]};
      if (r >= active_regions()) return ST_BAD;
      if (r >= first_locked_region()) return ST_LOCKED;
      case (off[3:0])
        SUB_LOW: begin
          shadow_region_low[r] = v & LOW_MASK;
          return ST_DONE;
        end
        SUB_HIGH: begin
          shadow_region_high[r] = v;
          return ST_DONE;
        end
        SUB_ATTRS: begin
          if (r == 0) shadow_region_attrs[r] = (v & ATTR0_MASK) | ATTR0_FORCE;
          else shadow_region_attrs[r] = v & ATTR_MASK;
          return ST_DONE;
        end
        default: return ST_BAD;
      endcase
    end
    case (off)
      OFF_ACTION: begin
        shadow_action = v[1:0];
        return ST_DONE;
      end
      OFF_LOCK_RNG: begin
        if (shadow_lock_select[0]) return ST_LOCKED;
        shadow_lock_range = v & LOCK_RNG_MASK;
        return ST_DONE;
      end
      OFF_LOCK_SEL: begin
        shadow_lock_select = v[2:0];
        return ST_DONE;
      end
      OFF_INT_CLR: return ST_DONE;
      OFF_SPEC: begin
        if (shadow_lock_select[2]) return ST_LOCKED;
        shadow_spec = v[1:0];
        return ST_DONE;
      end
      OFF_SEC_INV: begin
        if (shadow_lock_select[1]) return ST_LOCKED;
        shadow_sec_inv = v[0];
        return ST_DONE;
      end
      default: return ST_BAD;
    endcase
  endfunction

  function automatic access_result_t predict_access(bit mode, logic [11:0] off,
                                                     logic [31:0] v);
    access_result_t res;
    if (mode == ACC_WRITE) begin
      res.read_data = '0;
      res.status = apply_write(off, v);
    end else begin
      res = decode_read(off);
    end
    return res;
  endfunction

  task automatic clear_shadow();
    regions_setting = REGIONS_RESET;
    for (int i = 0; i < MAX_REGIONS_DEF; i++) begin
      shadow_region_low[i] = '0;
      shadow_region_high[i] = '0;
      shadow_region_attrs[i] = '0;
    end
    shadow_action = '0;
    shadow_lock_range = '0;
    shadow_lock_select = '0;
    shadow_spec = '0;
    shadow_sec_inv = 1'b0;
  endtask

  task automatic send_access(bit mode, logic [11:0] off, logic [31:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_offset <= off;
    in_write_data <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(predict_access(mode, off, v));
  endtask

  task automatic set_regions(logic [4:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    regions_setting = value;
  endtask

  task automatic send_random_access();
    bit          mode;
    logic [11:0] off;
    logic [31:0] v;
    int unsigned pick;
    mode = 1'($urandom_range(1));
    pick = $urandom_range(99);
    v = $urandom();
    if ($urandom_range(9) == 0) v = $urandom_range(1) ? ALL_ONES : '0;
    if (pick < 50) begin
      off = OFF_REGION_LO;
      off[7:4] = 4'($urandom_range(15));
      case ($urandom_range(9))
        0:       off[3:0] = 4'($urandom());
        1, 2, 3: off[3:0] = SUB_LOW;
        4, 5, 6: off[3:0] = SUB_HIGH;
        default: off[3:0] = SUB_ATTRS;
      endcase
    end else if (pick < 80) begin
      off = named_offsets[$urandom_range(20)];
    end else begin
      off = 12'($urandom());
    end
    if (off == OFF_LOCK_SEL && $urandom_range(1) == 1) v = '0;
    if (off == OFF_LOCK_RNG && $urandom_range(1) == 1) v[31] = 1'b0;
    send_access(mode, off, v);
  endtask

  task automatic test_id_and_config_reads();
    send_access(ACC_READ, OFF_CONFIG, ALL_ONES);
    send_access(ACC_READ, OFF_CELL3, '0);
  endtask

  task automatic test_region_masks();
    send_access(ACC_WRITE, region_offset(4'd0, SUB_ATTRS), ALL_ONES);
    send_access(ACC_READ, region_offset(4'd0, SUB_ATTRS), '0);
    send_access(ACC_WRITE, region_offset(4'd15, SUB_LOW), ALL_ONES);
    send_access(ACC_READ, region_offset(4'd15, SUB_LOW), '0);
    send_access(ACC_WRITE, region_offset(4'd15, SUB_ATTRS), ALL_ONES);
  endtask

  task automatic test_bad_offsets();
    send_access(ACC_READ, region_offset(4'd3, 4'hC), '0);
    send_access(ACC_WRITE, region_offset(4'd3, 4'hC), ALL_ONES);
    send_access(ACC_READ, OFF_REGION_HI | 12'h001, '0);
    send_access(ACC_WRITE, OFF_CONFIG, ALL_ONES);
    send_access(ACC_WRITE, OFF_INT_CLR, ALL_ONES);
  endtask

  task automatic test_lockdown();
    send_access(ACC_WRITE, OFF_LOCK_RNG, LOCK_RNG_MASK);
    send_access(ACC_WRITE, region_offset(4'd0, SUB_LOW), ALL_ONES);
    send_access(ACC_WRITE, OFF_LOCK_SEL, ALL_ONES);
    send_access(ACC_WRITE, OFF_LOCK_RNG, '0);
    send_access(ACC_WRITE, OFF_SPEC, ALL_ONES);
    send_access(ACC_WRITE, OFF_SEC_INV, ALL_ONES);
    send_access(ACC_WRITE, OFF_LOCK_SEL, '0);
    send_access(ACC_WRITE, OFF_LOCK_RNG, '0);
    send_access(ACC_WRITE, OFF_SPEC, ALL_ONES);
    send_access(ACC_WRITE, OFF_SEC_INV, ALL_ONES);
    send_access(ACC_WRITE, OFF_ACTION, ALL_ONES);
  endtask

  task automatic test_region_count();
    set_regions(5'd1);
    send_access(ACC_READ, region_offset(4'd1, SUB_LOW), '0);
    set_regions(5'd0);
    send_access(ACC_READ, OFF_CONFIG, '0);
    send_access(ACC_WRITE, region_offset(4'd1, SUB_HIGH), ALL_ONES);
  endtask

  task automatic test_random_traffic();
    logic [4:0] settings [9];
    settings = '{5'd16, 5'd5, 5'd31, 5'd1, 5'd0, 5'd9, 5'd0, 5'd16, 5'd0};
    settings[6] = 5'($urandom());
    settings[8] = 5'($urandom());
    for (int seg = 0; seg < 9; seg++) begin
      if (seg == 3) begin
        send_idle_pct = 62;
        stall_pct = 13;
      end
      if (seg == 6) begin
        send_idle_pct = 0;
        stall_pct = 0;
      end
      set_regions(settings[seg]);
      repeat (200) send_random_access();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result arrived with none expected: read_data %h status %0d",
               out_read_data, out_status);
        error_count++;
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_read_data !== oldest_result.read_data) begin
          $error("read_data: expected %h, actual %h", oldest_result.read_data, out_read_data);
          error_count++;
        end
        if (out_status !== oldest_result.status) begin
          $error("status: expected %0d, actual %0d", oldest_result.status, out_status);
          error_count++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n <= 1'b0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    in_valid <= 1'b0;
    in_mode <= ACC_READ;
    in_offset <= '0;
    in_write_data <= '0;
    out_stall <= 1'b0;
    clear_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_id_and_config_reads();
    test_region_masks();
    test_bad_offsets();
    test_lockdown();
    test_region_count();
    test_random_traffic();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
